/* rtl/core/sbsh_pkg.sv */
// ----------------------------------------------------------------------------
// sbsh_pkg
// Shared types, round constants and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sbsh_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       msg_end;
  } sbsh_in_t;

  typedef struct packed {
    logic [63:0] digest_w0;
    logic [63:0] digest_w1;
    logic [63:0] digest_w2;
    logic [63:0] digest_w3;
  } sbsh_out_t;

  typedef logic [0:7][31:0] sbsh_hash_t;

  typedef struct packed {
    logic       shift;
    logic [7:0] data;
    logic       start;
    logic       init;
  } sbsh_cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sbsh_cmp_stat_t;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam sbsh_hash_t HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

/* rtl/core/sbsh_compress.sv */
// ----------------------------------------------------------------------------
// sbsh_compress
// Block buffer, message schedule window and one-round-per-cycle compression.
// ----------------------------------------------------------------------------
module sbsh_compress (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sbsh_pkg::sbsh_cmp_ctrl_t ctrl_i,
  output sbsh_pkg::sbsh_cmp_stat_t stat_o,
  output sbsh_pkg::sbsh_hash_t     hash_o
);
  import sbsh_pkg::*;

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FIN   = 3'b100
  } cmp_state_e;

  cmp_state_e  cst_q, cst_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [511:0] blk_q;
  sbsh_hash_t  wv_q;
  sbsh_hash_t  hash_q;

  logic [31:0] w_cur, w_new, t1, t2, ch, maj;

  // blk_q holds the 16-word window, oldest word at the top
  assign w_cur = blk_q[511:480];
  assign w_new = small_sig1(blk_q[63:32]) + blk_q[223:192]
               + small_sig0(blk_q[479:448]) + w_cur;

  assign ch  = (wv_q[4] & wv_q[5]) ^ (~wv_q[4] & wv_q[6]);
  assign maj = (wv_q[0] & wv_q[1]) ^ (wv_q[0] & wv_q[2]) ^ (wv_q[1] & wv_q[2]);
  assign t1  = wv_q[7] + big_sig1(wv_q[4]) + ch + ROUND_K[rnd_q] + w_cur;
  assign t2  = big_sig0(wv_q[0]) + maj;

  always_comb begin
    cst_d = cst_q;
    rnd_d = rnd_q;
    unique case (cst_q)
      C_IDLE: begin
        if (ctrl_i.start) begin
          cst_d = C_ROUND;
          rnd_d = '0;
        end
      end
      C_ROUND: begin
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          cst_d = C_FIN;
        end
      end
      C_FIN: begin
        cst_d = C_IDLE;
      end
      default: begin
        cst_d = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cst_q  <= C_IDLE;
      rnd_q  <= '0;
      hash_q <= HASH_IV;
    end else begin
      cst_q <= cst_d;
      rnd_q <= rnd_d;
      if (cst_q == C_FIN) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + wv_q[i];
        end
      end else if (ctrl_i.init) begin
        hash_q <= HASH_IV;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cst_q == C_ROUND) begin
      blk_q <= {blk_q[479:0], w_new};
      wv_q  <= {t1 + t2, wv_q[0], wv_q[1], wv_q[2], wv_q[3] + t1, wv_q[4], wv_q[5],
                wv_q[6]};
    end else begin
      if (ctrl_i.shift) begin
        blk_q <= {blk_q[503:0], ctrl_i.data};
      end
      if (ctrl_i.start) begin
        wv_q <= hash_q;
      end
    end
  end

  assign stat_o.busy = (cst_q != C_IDLE);
  assign stat_o.done = (cst_q == C_FIN);
  assign hash_o      = hash_q;

endmodule

/* rtl/core/sha256_byte_stream_hasher_core.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// SHA-256 over a byte stream; one digest item per message.
// ----------------------------------------------------------------------------
// channel | valid      | stall       | payload
// in      | in_valid_i | in_stall_o  | in_item_i  (msg_byte, byte_valid, msg_end)
// out     | out_valid_o| out_stall_i | out_item_o (digest_w0 .. digest_w3)
//
// Each byte item is shifted into the block; the 64th byte of a block starts
// a compression (64 rounds of the shared round unit plus the hash update).
// An end item shifts in 9 to 72 padding bytes, one per cycle except while
// a full block compresses, runs one or two compressions and loads the digest.
// Reset loads the initial hash values and clears the byte count.
// A stalled output holds its item; input is stalled in every state but idle.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sbsh_pkg::sbsh_in_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sbsh_pkg::sbsh_out_t out_item_o
);
  import sbsh_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_COMP = 6'b000010,
    S_MARK = 6'b000100,
    S_ZERO = 6'b001000,
    S_LEN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e         state_q, state_d;
  state_e         ret_q, ret_d;
  logic [5:0]     fill_q, fill_d;
  logic [63:0]    total_q, total_d;
  logic [63:0]    len_q, len_d;
  logic           out_valid_q;
  sbsh_out_t      out_item_q;

  sbsh_cmp_ctrl_t cmp_ctrl;
  sbsh_cmp_stat_t cmp_stat;
  sbsh_hash_t     hash;

  logic acc, out_ready, out_load;

  assign in_stall_o = (state_q != S_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign out_ready  = !out_valid_q || !out_stall_i;

  sbsh_compress u_compress (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cmp_ctrl),
    .stat_o (cmp_stat),
    .hash_o (hash)
  );

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    fill_d   = fill_q;
    total_d  = total_q;
    len_d    = len_q;
    cmp_ctrl = '0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (in_item_i.byte_valid) begin
            cmp_ctrl.shift = 1'b1;
            cmp_ctrl.data  = in_item_i.msg_byte;
            fill_d  = fill_q + 6'd1;
            total_d = total_q + 64'd1;
            if (fill_q == 6'd63) begin
              cmp_ctrl.start = 1'b1;
              state_d = S_COMP;
              ret_d   = in_item_i.msg_end ? S_MARK : S_IDLE;
            end else if (in_item_i.msg_end) begin
              state_d = S_MARK;
            end
          end else if (in_item_i.msg_end) begin
            state_d = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmp_ctrl.shift = 1'b1;
        cmp_ctrl.data  = PAD_MARK;
        fill_d = fill_q + 6'd1;
        len_d  = {total_q[60:0], 3'b000};
        if (fill_q == 6'd63) begin
          cmp_ctrl.start = 1'b1;
          state_d = S_COMP;
          ret_d   = S_ZERO;
        end else if (fill_q == 6'd55) begin
          state_d = S_LEN;
        end else begin
          state_d = S_ZERO;
        end
      end
      S_ZERO: begin
        cmp_ctrl.shift = 1'b1;
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          cmp_ctrl.start = 1'b1;
          state_d = S_COMP;
          ret_d   = S_ZERO;
        end else if (fill_q == 6'd55) begin
          state_d = S_LEN;
        end
      end
      S_LEN: begin
        cmp_ctrl.shift = 1'b1;
        cmp_ctrl.data  = len_q[63:56];
        len_d  = {len_q[55:0], 8'h00};
        fill_d = fill_q + 6'd1;
        if (fill_q == 6'd63) begin
          cmp_ctrl.start = 1'b1;
          state_d = S_COMP;
          ret_d   = S_OUT;
        end
      end
      S_COMP: begin
        if (cmp_stat.done) begin
          state_d = ret_q;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_load      = 1'b1;
          cmp_ctrl.init = 1'b1;
          total_d       = '0;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      fill_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (out_load) begin
      out_item_q.digest_w0 <= {hash[0], hash[1]};
      out_item_q.digest_w1 <= {hash[2], hash[3]};
      out_item_q.digest_w2 <= {hash[4], hash[5]};
      out_item_q.digest_w3 <= {hash[6], hash[7]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef NO_ASSERTIONS
  a_fill_empty_at_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (fill_q == 6'd0))
    else $error("block not empty when digest is loaded");

  a_busy_only_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_stat.busy |-> (state_q == S_COMP))
    else $error("compression running outside the wait state");

  a_len_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LEN) |-> (fill_q[5:3] == 3'b111))
    else $error("length bytes placed outside the last eight positions");

  a_out_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (total_q == 64'd0) && out_valid_q)
    else $error("digest load did not restart the message");
`endif

endmodule
